@@ sv/pmiw_pkg.sv @@
package pmiw_pkg;

	// fixed field widths
	localparam int COORD_W    = 32;
	localparam int SQ_W       = 47;
	localparam int REG_W      = 63;
	localparam int FRACT_BITS = 32;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;

	// register map, one register per 8 bytes
	typedef enum logic [2:0] {
		REG_WRAP_MODE = 3'd0,
		REG_CELL_ROW0 = 3'd1,
		REG_CELL_ROW1 = 3'd2,
		REG_CELL_ROW2 = 3'd3,
		REG_INV_ROW0  = 3'd4,
		REG_INV_ROW1  = 3'd5,
		REG_INV_ROW2  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vec_x;
		logic signed [COORD_W-1:0] vec_y;
		logic signed [COORD_W-1:0] vec_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic        [SQ_W-1:0]    sq_length;
	} vec_out_t;

endpackage

@@ sv/periodic_minimum_image_wrap.sv @@
// Periodic minimum-image wrap of one Q16.16 3-vector in a triclinic cell. The vector is
// multiplied by the inverse cell matrix, each fraction is wrapped to [-0.5,0.5) (wrap_mode 0)
// or [0,1) (wrap_mode 1), and the fractions are multiplied back by the cell matrix; the
// result comes with its squared length (Q31.16, saturating). The block takes one word per
// clock while in_stall is low; each result passes through two multiply stages, two
// adder-tree stages, a squaring stage and the output register, with one 32x21, 33x21 or
// 32x32 multiplier per product. Stall ripples back only through occupied stages, so bubbles
// are squeezed out and in_stall is high only when every stage holds a word and the output
// is stalled. Matrices and the mode are read directly from the APB registers (8-byte
// spacing, 64-bit data) and may only be written while no word is in flight; there is no
// check that the inverse matches the cell.
module periodic_minimum_image_wrap
	import pmiw_pkg::*;
#(
	parameter int COORD_FRAC_BITS   = 16,
	parameter int MATRIX_ENTRY_BITS = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  vec_in_t               in_word,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output vec_out_t              out_word,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int MEB       = MATRIX_ENTRY_BITS;
	localparam int INV_FRAC  = MEB - 2;
	localparam int CELL_FRAC = MEB - 10;
	// shift from the v*inv scale down to 32 fraction bits (may be negative)
	localparam int FSH       = COORD_FRAC_BITS + INV_FRAC - FRACT_BITS;
	// shift from the f*cell scale back to coordinate scale
	localparam int BACK      = FRACT_BITS + CELL_FRAC - COORD_FRAC_BITS;
	localparam int P1W       = COORD_W + MEB;          // vector times inverse entry
	localparam int S2W       = P1W + 2;                // sum of three of them
	localparam int EXW       = S2W + FRACT_BITS;       // sum padded for a left shift
	localparam int FW        = FRACT_BITS + 1;         // wrapped fraction, signed
	localparam int P3W       = FW + MEB;               // fraction times cell entry
	localparam int S4W       = P3W + 2;                // sum of three of them
	localparam int SQP       = 2 * COORD_W;            // one square
	localparam int SQS       = SQP + 1;                // sum of squares

	localparam logic signed [S4W-1:0] ROUND_BACK = S4W'(1) << (BACK - 1);
	localparam logic        [SQS-1:0] ROUND_SQ   = SQS'(1) << (COORD_FRAC_BITS - 1);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic             wrap_q;
	logic [REG_W-1:0] cell_q [3];
	logic [REG_W-1:0] inv_q  [3];
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity matrices at the two entry scales
			wrap_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cell_q[i] <= REG_W'(1) << (CELL_FRAC + i * MEB);
				inv_q[i]  <= REG_W'(1) << (INV_FRAC + i * MEB);
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WRAP_MODE: wrap_q    <= pwdata[0];
				REG_CELL_ROW0: cell_q[0] <= pwdata[REG_W-1:0];
				REG_CELL_ROW1: cell_q[1] <= pwdata[REG_W-1:0];
				REG_CELL_ROW2: cell_q[2] <= pwdata[REG_W-1:0];
				REG_INV_ROW0:  inv_q[0]  <= pwdata[REG_W-1:0];
				REG_INV_ROW1:  inv_q[1]  <= pwdata[REG_W-1:0];
				REG_INV_ROW2:  inv_q[2]  <= pwdata[REG_W-1:0];
				default: ;   // unused slot, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WRAP_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, wrap_q};
			REG_CELL_ROW0: prdata = {1'b0, cell_q[0]};
			REG_CELL_ROW1: prdata = {1'b0, cell_q[1]};
			REG_CELL_ROW2: prdata = {1'b0, cell_q[2]};
			REG_INV_ROW0:  prdata = {1'b0, inv_q[0]};
			REG_INV_ROW1:  prdata = {1'b0, inv_q[1]};
			REG_INV_ROW2:  prdata = {1'b0, inv_q[2]};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline flow control
	// ------------------------------------------------------------------
	// a stage may load when it is empty or the next stage loads too
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6    = !v_s6 || !out_stall;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: v_i * inv[i][j], nine products
	// ------------------------------------------------------------------
	logic signed [COORD_W-1:0] vin [3];
	logic signed [P1W-1:0]     p_s1 [3][3];

	assign vin[0] = in_word.vec_x;
	assign vin[1] = in_word.vec_y;
	assign vin[2] = in_word.vec_z;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i][j] <= P1W'(vin[i]) * P1W'($signed(inv_q[i][j*MEB +: MEB]));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 2: column sums, cut to 32 fraction bits, wrap
	// ------------------------------------------------------------------
	logic signed [S2W-1:0] fsum [3];
	logic        [EXW-1:0] fext [3];
	logic [FRACT_BITS-1:0] fr   [3];
	logic signed [FW-1:0]  f_s2 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			fsum[j] = S2W'(p_s1[0][j]) + S2W'(p_s1[1][j]) + S2W'(p_s1[2][j]);
			fext[j] = {fsum[j], {FRACT_BITS{1'b0}}};
			// low bits dropped = floor; the high bits fall away mod 1
			fr[j]   = fext[j][FSH + FRACT_BITS +: FRACT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int j = 0; j < 3; j++) begin
				// position mode keeps [0,1), difference mode reads it as [-0.5,0.5)
				f_s2[j] <= wrap_q ? {1'b0, fr[j]} : {fr[j][FRACT_BITS-1], fr[j]};
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 3: f_i * cell[i][j], nine products
	// ------------------------------------------------------------------
	logic signed [P3W-1:0] p_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s3[i][j] <= P3W'(f_s2[i]) * P3W'($signed(cell_q[i][j*MEB +: MEB]));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 4: column sums, round half up, saturate to 32 bits
	// ------------------------------------------------------------------
	logic signed [S4W-1:0]     wsum [3];
	logic signed [S4W-1:0]     wsh  [3];
	logic signed [COORD_W-1:0] wsat [3];
	logic signed [COORD_W-1:0] w_s4 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			wsum[j] = S4W'(p_s3[0][j]) + S4W'(p_s3[1][j]) + S4W'(p_s3[2][j]) + ROUND_BACK;
			wsh[j]  = wsum[j] >>> BACK;
			if (!wsh[j][S4W-1] && (|wsh[j][S4W-2:COORD_W-1])) begin
				wsat[j] = {1'b0, {(COORD_W-1){1'b1}}};
			end else if (wsh[j][S4W-1] && !(&wsh[j][S4W-2:COORD_W-1])) begin
				wsat[j] = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				wsat[j] = wsh[j][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int j = 0; j < 3; j++) begin
				w_s4[j] <= wsat[j];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 5: squares
	// ------------------------------------------------------------------
	logic signed [COORD_W-1:0] w_s5  [3];
	logic signed [SQP-1:0]     sqp   [3];
	logic        [SQP-1:0]     sq_s5 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sqp[j] = SQP'(w_s4[j]) * SQP'(w_s4[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			for (int j = 0; j < 3; j++) begin
				w_s5[j]  <= w_s4[j];
				sq_s5[j] <= sqp[j];
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 6: sum of squares, round, saturate; output register
	// ------------------------------------------------------------------
	logic [SQS-1:0]  sq_tot;
	logic [SQS-1:0]  sq_sh;
	logic [SQ_W-1:0] sq_sat;
	vec_out_t        word_s6;

	always_comb begin
		sq_tot = SQS'(sq_s5[0]) + SQS'(sq_s5[1]) + SQS'(sq_s5[2]) + ROUND_SQ;
		sq_sh  = sq_tot >> COORD_FRAC_BITS;
		sq_sat = (|sq_sh[SQS-1:SQ_W]) ? {SQ_W{1'b1}} : sq_sh[SQ_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			word_s6.out_x     <= w_s5[0];
			word_s6.out_y     <= w_s5[1];
			word_s6.out_z     <= w_s5[2];
			word_s6.sq_length <= sq_sat;
		end
	end

	assign out_valid = v_s6;
	assign out_word  = word_s6;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// back-pressure only when the whole pipe is full behind a stalled output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled while the pipeline has room");

	// an accepted word always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted word lost at pipeline entry");

	// a zero vector has zero length
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.out_x == '0 && out_word.out_y == '0 &&
		 out_word.out_z == '0) |-> (out_word.sq_length == '0))
		else $error("nonzero length for a zero vector");

endmodule

@@ dv/testbench.sv @@
module testbench;
	import pmiw_pkg::*;

	// fixed-point layout of the block at its default parameters
	localparam int COORD_FRAC     = 16;
	localparam int CELL_FRAC      = 11;
	localparam int INV_FRAC       = 19;
	localparam int ENTRY_W        = 21;
	// fraction product is cut down to FRACT_BITS fraction bits
	localparam int FRAC_SHIFT     = COORD_FRAC + INV_FRAC - FRACT_BITS;
	// fraction times cell product goes back to Q16.16
	localparam int BACK_SHIFT     = FRACT_BITS + CELL_FRAC - COORD_FRAC;
	localparam longint COORD_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN  = -64'sd2147483648;
	localparam logic [63:0] SQ_CEIL = (64'd1 << SQ_W) - 64'd1;
	localparam logic [ENTRY_W-1:0] ENTRY_MAX = 21'h0F_FFFF;
	localparam logic [ENTRY_W-1:0] ENTRY_MIN = 21'h10_0000;

	// run control
	localparam int SETTLE_CYCLES  = 10;     // six-stage pipeline plus margin
	localparam int IDLE_CEILING   = 13;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int PHASES         = 12;
	localparam int WORDS_PER_PHASE = 154;
	localparam int UNMAPPED_IDX   = 7;      // first index past the register map
	localparam int REG_COUNT      = 7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	vec_in_t               in_word;
	logic                  out_valid;
	logic                  out_stall;
	vec_out_t              out_word;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow copy of the register file, updated on every config write
	logic                  wrap_pos;
	logic [REG_W-1:0]      cell_rows [3];
	logic [REG_W-1:0]      inv_rows [3];

	// wrapped vectors still owed by the block, oldest first
	vec_out_t              pending_wraps [$];
	int                    errors;
	int                    results_seen;
	int                    in_idle_max;
	int                    out_idle_max;

	periodic_minimum_image_wrap dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// signed matrix entry j of a packed row
	function automatic longint entry_of(logic [REG_W-1:0] row, int j);
		logic signed [ENTRY_W-1:0] e;
		e = row[j*ENTRY_W +: ENTRY_W];
		return e;
	endfunction

	// minimum-image / position wrap of one vector with the shadow registers
	function automatic vec_out_t wrap_vector(vec_in_t word);
		longint      v [3];
		longint      f [3];
		longint      r [3];
		longint      acc;
		logic [31:0] fr;
		logic [63:0] sq;
		vec_out_t    res;
		v[0] = $signed(word.vec_x);
		v[1] = $signed(word.vec_y);
		v[2] = $signed(word.vec_z);
		// fractional coordinates, floored to 32 fraction bits, wrapped mod 1
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += v[i] * entry_of(inv_rows[i], j);
			fr = acc[FRAC_SHIFT +: 32];
			if (wrap_pos)
				f[j] = {32'd0, fr};        // [0,1)
			else
				f[j] = $signed(fr);        // [-0.5,0.5)
		end
		// back to cartesian, round half up, saturate to 32 bits
		sq = '0;
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += f[i] * entry_of(cell_rows[i], j);
			r[j] = (acc + (64'sd1 <<< (BACK_SHIFT - 1))) >>> BACK_SHIFT;
			if (r[j] > COORD_MAX)
				r[j] = COORD_MAX;
			if (r[j] < COORD_MIN)
				r[j] = COORD_MIN;
			sq += r[j] * r[j];
		end
		sq = (sq + (64'd1 << (COORD_FRAC - 1))) >> COORD_FRAC;
		if (sq > SQ_CEIL)
			sq = SQ_CEIL;
		res.out_x     = 32'(r[0]);
		res.out_y     = 32'(r[1]);
		res.out_z     = 32'(r[2]);
		res.sq_length = sq[SQ_W-1:0];
		return res;
	endfunction

	function automatic void reset_shadow();
		wrap_pos     = 1'b0;
		cell_rows[0] = 63'd1 << CELL_FRAC;
		cell_rows[1] = cell_rows[0] << ENTRY_W;
		cell_rows[2] = cell_rows[1] << ENTRY_W;
		inv_rows[0]  = 63'd1 << INV_FRAC;
		inv_rows[1]  = inv_rows[0] << ENTRY_W;
		inv_rows[2]  = inv_rows[1] << ENTRY_W;
	endfunction

	// unused bits are dropped, unmapped indexes ignored
	function automatic void apply_reg(int index, logic [63:0] value);
		case (reg_idx_t'(index[2:0]))
			REG_WRAP_MODE: wrap_pos     = value[0];
			REG_CELL_ROW0: cell_rows[0] = value[REG_W-1:0];
			REG_CELL_ROW1: cell_rows[1] = value[REG_W-1:0];
			REG_CELL_ROW2: cell_rows[2] = value[REG_W-1:0];
			REG_INV_ROW0:  inv_rows[0]  = value[REG_W-1:0];
			REG_INV_ROW1:  inv_rows[1]  = value[REG_W-1:0];
			REG_INV_ROW2:  inv_rows[2]  = value[REG_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [63:0] shadow_value(int index);
		case (reg_idx_t'(index[2:0]))
			REG_WRAP_MODE: return {63'd0, wrap_pos};
			REG_CELL_ROW0: return {1'b0, cell_rows[0]};
			REG_CELL_ROW1: return {1'b0, cell_rows[1]};
			REG_CELL_ROW2: return {1'b0, cell_rows[2]};
			REG_INV_ROW0:  return {1'b0, inv_rows[0]};
			REG_INV_ROW1:  return {1'b0, inv_rows[1]};
			REG_INV_ROW2:  return {1'b0, inv_rows[2]};
			default:       return '0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch %0d: %s", errors, what);
	endtask

	// a third of the draws are forced to zero so back-to-back runs are common
	function automatic int draw_idle(int ceiling);
		if (ceiling == 0 || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, ceiling);
	endfunction

	function automatic vec_in_t make_vec(int x, int y, int z);
		vec_in_t w;
		w.vec_x = x;
		w.vec_y = y;
		w.vec_z = z;
		return w;
	endfunction

	function automatic int to_coord(real x);
		real s;
		s = x * (2.0 ** COORD_FRAC);
		if (s > 2147483647.0)
			s = 2147483647.0;
		if (s < -2147483648.0)
			s = -2147483648.0;
		return $rtoi(s);
	endfunction

	function automatic logic [ENTRY_W-1:0] quantize(real x, int frac);
		longint t;
		t = $rtoi(x * (2.0 ** frac));
		if (t > 64'sd1048575)
			t = 64'sd1048575;
		if (t < -64'sd1048576)
			t = -64'sd1048576;
		return t[ENTRY_W-1:0];
	endfunction

	// one APB transfer: setup, access until pready, then idle with psel low
	task automatic reg_access(input logic wr, input int index, input logic [63:0] wdata,
	                          output logic [63:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_W'(index * 8);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input int index, input logic [63:0] value);
		logic [63:0] unused;
		reg_access(1'b1, index, value, unused);
		apply_reg(index, value);
	endtask

	task automatic reg_check(input int index);
		logic [63:0] got;
		reg_access(1'b0, index, '0, got);
		if (got !== shadow_value(index))
			report_mismatch($sformatf("register %0d reads %h, want %h",
			                          index, got, shadow_value(index)));
	endtask

	// hand one word to the block, then queue its predicted result
	task automatic send_vector(input vec_in_t word);
		int gap;
		gap = draw_idle(in_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= word;
		do
			@(posedge clk);
		while (in_stall);
		pending_wraps.push_back(wrap_vector(word));
	endtask

	// drop valid and let the pipeline empty completely
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_wraps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_identity();
		for (int i = 0; i < 3; i++) begin
			reg_write(REG_CELL_ROW0 + i, 64'd1 << (CELL_FRAC + i * ENTRY_W));
			reg_write(REG_INV_ROW0 + i, 64'd1 << (INV_FRAC + i * ENTRY_W));
		end
	endtask

	// random triclinic cell with its inverse, both quantized to register format
	task automatic load_cell();
		real c [3][3];
		real inv [3][3];
		real det;
		c[0][0] = 2.0 + $urandom_range(0, 3800) / 100.0;
		c[0][1] = 0.0;
		c[0][2] = 0.0;
		c[1][0] = ($urandom_range(0, 2000) - 1000.0) / 2000.0 * c[0][0];
		c[1][1] = 2.0 + $urandom_range(0, 3800) / 100.0;
		c[1][2] = 0.0;
		c[2][0] = ($urandom_range(0, 2000) - 1000.0) / 2000.0 * c[0][0];
		c[2][1] = ($urandom_range(0, 2000) - 1000.0) / 2000.0 * c[1][1];
		c[2][2] = 2.0 + $urandom_range(0, 3800) / 100.0;
		det = c[0][0] * (c[1][1] * c[2][2] - c[1][2] * c[2][1])
		    - c[0][1] * (c[1][0] * c[2][2] - c[1][2] * c[2][0])
		    + c[0][2] * (c[1][0] * c[2][1] - c[1][1] * c[2][0]);
		// adjugate by cyclic cofactors
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				inv[i][j] = (c[(j+1)%3][(i+1)%3] * c[(j+2)%3][(i+2)%3]
				           - c[(j+1)%3][(i+2)%3] * c[(j+2)%3][(i+1)%3]) / det;
		for (int i = 0; i < 3; i++) begin
			reg_write(REG_CELL_ROW0 + i, {1'b0, quantize(c[i][2], CELL_FRAC),
			          quantize(c[i][1], CELL_FRAC), quantize(c[i][0], CELL_FRAC)});
			reg_write(REG_INV_ROW0 + i, {1'b0, quantize(inv[i][2], INV_FRAC),
			          quantize(inv[i][1], INV_FRAC), quantize(inv[i][0], INV_FRAC)});
		end
	endtask

	// arbitrary bit patterns, top bit included so the drop on write is seen
	task automatic load_random_registers();
		for (int i = 0; i < 3; i++) begin
			reg_write(REG_CELL_ROW0 + i, {$urandom(), $urandom()});
			reg_write(REG_INV_ROW0 + i, {$urandom(), $urandom()});
		end
	endtask

	// kind 0: raw bits; 1: half-integer fractions (wrap boundary); else random
	// fractions a few cells out, mapped through the current cell
	function automatic vec_in_t pick_vector(int kind);
		real     f [3];
		real     x;
		int      comp [3];
		vec_in_t word;
		if (kind == 0) begin
			word = {$urandom(), $urandom(), $urandom()};
			return word;
		end
		for (int i = 0; i < 3; i++)
			if (kind == 1)
				f[i] = ($urandom_range(0, 8) - 4.0) / 2.0;
			else
				f[i] = ($urandom_range(0, 6000) - 3000.0) / 1000.0;
		for (int j = 0; j < 3; j++) begin
			x = 0.0;
			for (int i = 0; i < 3; i++)
				x += f[i] * entry_of(cell_rows[i], j) / (2.0 ** CELL_FRAC);
			comp[j] = to_coord(x);
		end
		return make_vec(comp[0], comp[1], comp[2]);
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_reset_values();
		for (int i = 0; i < REG_COUNT; i++)
			reg_check(i);
	endtask

	// random writes with unused bits set, read back, and an unmapped write
	task automatic test_register_access();
		for (int i = 0; i < REG_COUNT; i++) begin
			reg_write(i, {1'b1, $urandom(), 31'($urandom())});
			reg_check(i);
		end
		reg_write(REG_WRAP_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		reg_check(REG_WRAP_MODE);
		reg_write(UNMAPPED_IDX, {$urandom(), $urandom()});
		for (int i = 0; i < REG_COUNT; i++)
			reg_check(i);
	endtask

	// identity cell: the wrap points at +-0.5, 1.0, -1.5 and field extremes
	task automatic test_wrap_boundaries();
		load_identity();
		in_idle_max  = IDLE_CEILING;
		out_idle_max = IDLE_CEILING;
		for (int m = 0; m < 2; m++) begin
			reg_write(REG_WRAP_MODE, 64'(m));
			send_vector(make_vec(0, 0, 0));
			send_vector(make_vec(32'h7FFF_FFFF, 32'h8000_0000, -1));
			// +0.5, -0.5, just under +0.5
			send_vector(make_vec(32'h0000_8000, 32'hFFFF_8000, 32'h0000_7FFF));
			// 1.0, -1.0, 1.5
			send_vector(make_vec(32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000));
			// -1.5, -2.0, just below -0.5: position wrap below -1
			send_vector(make_vec(32'hFFFE_8000, 32'hFFFE_0000, 32'hFFFF_7FFF));
			send_vector(make_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
			wait_all_results();
		end
	endtask

	// every matrix entry at its most positive, then most negative value
	task automatic test_extreme_matrices();
		logic [ENTRY_W-1:0] e;
		for (int s = 0; s < 2; s++) begin
			e = s ? ENTRY_MIN : ENTRY_MAX;
			for (int i = 0; i < 3; i++) begin
				reg_write(REG_CELL_ROW0 + i, {1'b0, e, e, e});
				reg_write(REG_INV_ROW0 + i, {1'b0, e, e, e});
			end
			for (int m = 0; m < 2; m++) begin
				reg_write(REG_WRAP_MODE, 64'(m));
				send_vector(make_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
				send_vector(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
				wait_all_results();
			end
		end
	endtask

	// phases of random words, each with its own cell, mode and idling mix
	task automatic test_random_streams();
		int kind;
		for (int p = 0; p < PHASES; p++) begin
			in_idle_max  = (p % 3 == 1) ? 0 : IDLE_CEILING;
			out_idle_max = (p % 3 == 1 || p % 4 == 2) ? 0 : IDLE_CEILING;
			if (p % 4 == 3)
				load_random_registers();
			else
				load_cell();
			reg_write(REG_WRAP_MODE, 64'(p % 2));
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// in even phases the sender holds off mid-phase until the pipe has drained
				if (n == WORDS_PER_PHASE / 2 && p % 2 == 0)
					wait_all_results();
				kind = $urandom_range(0, 9);
				send_vector(pick_vector(kind));
			end
			wait_all_results();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_word  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		errors       = 0;
		results_seen = 0;
		in_idle_max  = IDLE_CEILING;
		out_idle_max = IDLE_CEILING;
		reset_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_wrap_boundaries();
		test_extreme_matrices();
		test_random_streams();

		wait_all_results();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// output side: random stall per word, compare each accepted word in order
	initial begin : result_checker
		int       stall_left;
		vec_out_t want;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_wraps.size() == 0) begin
					report_mismatch($sformatf("result %0d with no word in flight",
					                          results_seen));
				end else begin
					want = pending_wraps.pop_front();
					if (out_word.out_x !== want.out_x)
						report_mismatch($sformatf("result %0d out_x %h, want %h",
						                results_seen, out_word.out_x, want.out_x));
					if (out_word.out_y !== want.out_y)
						report_mismatch($sformatf("result %0d out_y %h, want %h",
						                results_seen, out_word.out_y, want.out_y));
					if (out_word.out_z !== want.out_z)
						report_mismatch($sformatf("result %0d out_z %h, want %h",
						                results_seen, out_word.out_z, want.out_z));
					if (out_word.sq_length !== want.sq_length)
						report_mismatch($sformatf("result %0d sq_length %h, want %h",
						                results_seen, out_word.sq_length,
						                want.sq_length));
				end
				stall_left = draw_idle(out_idle_max);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// hang guard
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
